// ===== src/sms_pkg.sv =====
// Shared types and codes for the sorted matrix search block.
package sms_pkg;

	// Item function codes
	localparam logic FUNC_WRITE = 1'b0;
	localparam logic FUNC_QUERY = 1'b1;

	// Configuration register indexes
	localparam logic REG_ROW_COUNT    = 1'b0;
	localparam logic REG_COLUMN_COUNT = 1'b1;

	localparam int COUNT_W = 6;
	localparam int INDEX_W = 5;
	localparam int DATA_W  = 32;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_WALK,
		ST_FINISH
	} state_t;

	// Commands from controller to datapath
	typedef struct packed {
		logic write_entry;
		logic start;
		logic move_up;
		logic move_right;
		logic set_outcome;
		logic outcome_bit;
		logic publish;
	} cmd_t;

	// Status from datapath to controller
	typedef struct packed {
		logic empty;
		logic hit;
		logic above;
		logic at_top;
		logic last_col;
	} sts_t;

endpackage

// ===== src/sms_ctrl.sv =====
// Controller state machine for the staircase search.
module sms_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  logic          func,
	output logic          out_valid,
	input  logic          out_ready,
	input  sms_pkg::sts_t sts,
	output sms_pkg::cmd_t cmd
);
	import sms_pkg::*;

	state_t state_q, state_d;
	logic   out_valid_q;
	logic   accept;
	logic   out_free;

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;
	assign accept    = in_valid && in_ready;
	assign out_free  = !out_valid_q || out_ready;

	// State and output valid registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.publish) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Next state and commands
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (accept && func == FUNC_WRITE) begin
					cmd.write_entry = 1'b1;
				end else if (accept) begin
					cmd.start = 1'b1;
					if (sts.empty) begin
						cmd.set_outcome = 1'b1;
						cmd.outcome_bit = 1'b0;
						state_d         = ST_FINISH;
					end else begin
						state_d = ST_WALK;
					end
				end
			end
			ST_WALK: begin
				priority if (sts.hit) begin
					cmd.set_outcome = 1'b1;
					cmd.outcome_bit = 1'b1;
					state_d         = ST_FINISH;
				end else if (sts.above && sts.at_top) begin
					cmd.set_outcome = 1'b1;
					cmd.outcome_bit = 1'b0;
					state_d         = ST_FINISH;
				end else if (sts.above) begin
					cmd.move_up = 1'b1;
				end else if (sts.last_col) begin
					cmd.set_outcome = 1'b1;
					cmd.outcome_bit = 1'b0;
					state_d         = ST_FINISH;
				end else begin
					cmd.move_right = 1'b1;
				end
			end
			ST_FINISH: begin
				// hand the found flag to the output register once it is free
				if (out_free) begin
					cmd.publish = 1'b1;
					state_d     = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

// ===== src/sms_datapath.sv =====
// Matrix memory, walk position, key and result registers.
module sms_datapath #(
	parameter int MAX_ROWS    = 32,
	parameter int MAX_COLUMNS = 32
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_write,
	input  logic                         cfg_index,
	input  logic [sms_pkg::COUNT_W-1:0]  cfg_data,
	input  logic [sms_pkg::INDEX_W-1:0]  row_index,
	input  logic [sms_pkg::INDEX_W-1:0]  column_index,
	input  logic signed [sms_pkg::DATA_W-1:0] entry_value,
	input  logic signed [sms_pkg::DATA_W-1:0] target,
	input  sms_pkg::cmd_t                cmd,
	output sms_pkg::sts_t                sts,
	output logic                         found
);
	import sms_pkg::*;

	localparam int DEPTH = MAX_ROWS * MAX_COLUMNS;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam logic [COUNT_W-1:0] ROW_CAP =
		(MAX_ROWS > 63) ? 6'd63 : COUNT_W'(MAX_ROWS);
	localparam logic [COUNT_W-1:0] COL_CAP =
		(MAX_COLUMNS > 63) ? 6'd63 : COUNT_W'(MAX_COLUMNS);

	logic [DATA_W-1:0]        matrix_mem_q [DEPTH];
	logic signed [DATA_W-1:0] rd_data_q;
	logic signed [DATA_W-1:0] key_q;
	logic [COUNT_W-1:0]       row_count_q, column_count_q;
	logic [COUNT_W-1:0]       rows_eff, cols_eff;
	logic [COUNT_W-1:0]       walk_row_q, walk_col_q;
	logic [AW-1:0]            addr_q, addr_d, start_addr, wr_addr;
	logic                     wr_in_range;
	logic                     outcome_q, found_q;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_count_q    <= '0;
			column_count_q <= '0;
		end else if (cfg_write) begin
			unique case (cfg_index)
				REG_ROW_COUNT:    row_count_q    <= cfg_data;
				REG_COLUMN_COUNT: column_count_q <= cfg_data;
				default:          ;
			endcase
		end
	end

	// Counts limited to the store size
	assign rows_eff = (row_count_q > ROW_CAP) ? ROW_CAP : row_count_q;
	assign cols_eff = (column_count_q > COL_CAP) ? COL_CAP : column_count_q;

	assign start_addr  = AW'(32'(rows_eff - 6'd1) * MAX_COLUMNS);
	assign wr_addr     = AW'(32'(row_index) * MAX_COLUMNS + 32'(column_index));
	assign wr_in_range = (32'(row_index) < MAX_ROWS) && (32'(column_index) < MAX_COLUMNS);

	// Next walk address: start at bottom-left, up is one row back, right is next word
	always_comb begin
		priority if (cmd.start) begin
			addr_d = start_addr;
		end else if (cmd.move_up) begin
			addr_d = addr_q - AW'(MAX_COLUMNS);
		end else if (cmd.move_right) begin
			addr_d = addr_q + AW'(1);
		end else begin
			addr_d = addr_q;
		end
	end

	// Walk position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			walk_row_q <= '0;
			walk_col_q <= '0;
		end else begin
			priority if (cmd.start) begin
				walk_row_q <= rows_eff - 6'd1;
				walk_col_q <= '0;
			end else if (cmd.move_up) begin
				walk_row_q <= walk_row_q - 6'd1;
			end else if (cmd.move_right) begin
				walk_col_q <= walk_col_q + 6'd1;
			end
		end
	end

	// Address and key registers
	always_ff @(posedge clk) begin
		addr_q <= addr_d;
		if (cmd.start) begin
			key_q <= target;
		end
	end

	// Matrix memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (cmd.write_entry && wr_in_range) begin
			matrix_mem_q[wr_addr] <= entry_value;
		end
	end

	always_ff @(posedge clk) begin
		rd_data_q <= matrix_mem_q[addr_d];
	end

	// Outcome holding and output flag
	always_ff @(posedge clk) begin
		if (cmd.set_outcome) begin
			outcome_q <= cmd.outcome_bit;
		end
		if (cmd.publish) begin
			found_q <= outcome_q;
		end
	end

	assign found = found_q;

	// Status toward the controller
	assign sts.empty    = (rows_eff == '0) || (cols_eff == '0);
	assign sts.hit      = (rd_data_q == key_q);
	assign sts.above    = (rd_data_q > key_q);
	assign sts.at_top   = (walk_row_q == '0);
	assign sts.last_col = (walk_col_q == cols_eff - 6'd1);

endmodule

// ===== src/sorted_matrix_search.sv =====
// Top level: search for a value in a row- and column-sorted matrix.
//
// Items arrive on a valid/ready input channel. A write item (func = 0) stores
// entry_value at row_index, column_index and gives no
// result. A query item (func = 1) walks the matrix from the bottom-left entry,
// going up past larger entries and right past smaller ones, and returns one
// found flag on the valid/ready output channel.
// A query visits one entry per cycle, limited by the single read port of the
// matrix memory, then loads its found flag into the result register. The next
// item is taken the cycle after the result is loaded; writes go one per cycle.
// row_count and column_count are to be written on the configuration port
// while the block is idle; the block itself does not enforce this. Reset clears
// the counts, the walk position and the output valid; matrix entries hold no
// value until written. A stalled receiver holds the result; a finished query
// waits for the output register to free before the block takes its next item.
module sorted_matrix_search #(
	parameter int MAX_ROWS    = 32,
	parameter int MAX_COLUMNS = 32
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_write,
	input  logic                              cfg_index,
	input  logic [sms_pkg::COUNT_W-1:0]       cfg_data,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic                              func,
	input  logic [sms_pkg::INDEX_W-1:0]       row_index,
	input  logic [sms_pkg::INDEX_W-1:0]       column_index,
	input  logic signed [sms_pkg::DATA_W-1:0] entry_value,
	input  logic signed [sms_pkg::DATA_W-1:0] target,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic                              found
);
	import sms_pkg::*;

	cmd_t cmd;
	sts_t sts;

	// Controller
	sms_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.func      (func),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	// Datapath
	sms_datapath #(
		.MAX_ROWS    (MAX_ROWS),
		.MAX_COLUMNS (MAX_COLUMNS)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_write    (cfg_write),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.row_index    (row_index),
		.column_index (column_index),
		.entry_value  (entry_value),
		.target       (target),
		.cmd          (cmd),
		.sts          (sts),
		.found        (found)
	);

endmodule

// ===== src/sms_checker.sv =====
// Port-level checks for the sorted matrix search, bound to the top level.
module sms_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic func,
	input logic out_valid,
	input logic out_ready,
	input logic found
);
	import sms_pkg::*;

	// A held result keeps its flag until taken
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(found))
		else $error("result changed while stalled");

	// A write leaves the block ready again in the next cycle
	a_write_one_cycle: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && func == FUNC_WRITE |=> in_ready)
		else $error("block busy after a write item");

	// A query keeps the block busy
	a_query_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && func == FUNC_QUERY |=> !in_ready)
		else $error("item taken during a query");

	// A result appears only at the end of a busy period
	a_result_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(!in_ready))
		else $error("result without a query in progress");

endmodule

bind sorted_matrix_search sms_checker u_sms_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.func      (func),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.found     (found)
);

// ===== dv/sorted_matrix_search_check.sv =====
`timescale 1ns / 100ps
// Checker for the sorted matrix search block: watches both channels, predicts and compares.
module sorted_matrix_search_check (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_write,
	input  logic                              cfg_index,
	input  logic [sms_pkg::COUNT_W-1:0]       cfg_data,
	input  logic                              in_valid,
	input  logic                              in_ready,
	input  logic                              func,
	input  logic [sms_pkg::INDEX_W-1:0]       row_index,
	input  logic [sms_pkg::INDEX_W-1:0]       column_index,
	input  logic signed [sms_pkg::DATA_W-1:0] entry_value,
	input  logic signed [sms_pkg::DATA_W-1:0] target,
	input  logic                              out_valid,
	input  logic                              out_ready,
	input  logic                              found,
	output int                                pending,
	output int                                failures
);
	import sms_pkg::*;

	localparam int GRID = 32;

	// One predicted search outcome, with the value searched for
	typedef struct {
		logic                     hit;
		logic signed [DATA_W-1:0] key;
	} search_outcome_t;

	logic signed [DATA_W-1:0] cells [GRID][GRID];
	logic [COUNT_W-1:0]       rows_reg;
	logic [COUNT_W-1:0]       cols_reg;
	search_outcome_t          outcomes_due [$];

	// Walk from the bottom-left corner: up past larger entries, right past smaller
	function automatic logic staircase_hit(input logic signed [DATA_W-1:0] key);
		int rows;
		int cols;
		int r;
		int c;
		rows = (rows_reg > GRID) ? GRID : int'(rows_reg);
		cols = (cols_reg > GRID) ? GRID : int'(cols_reg);
		if (rows == 0 || cols == 0)
			return 1'b0;
		r = rows - 1;
		c = 0;
		while (r >= 0 && c < cols) begin
			if (cells[r][c] == key)
				return 1'b1;
			if (cells[r][c] > key)
				r--;
			else
				c++;
		end
		return 1'b0;
	endfunction

	// Track config and stored entries, queue predictions, check each result item
	always @(posedge clk or negedge arst_n) begin : watch
		search_outcome_t due;
		if (!arst_n) begin
			rows_reg = '0;
			cols_reg = '0;
			outcomes_due.delete();
			failures = 0;
			pending <= 0;
		end else begin
			if (cfg_write) begin
				if (cfg_index == REG_ROW_COUNT)
					rows_reg = cfg_data;
				else
					cols_reg = cfg_data;
			end
			if (in_valid && in_ready) begin
				if (func == FUNC_WRITE)
					cells[row_index][column_index] = entry_value;
				else
					outcomes_due.push_back('{staircase_hit(target), target});
			end
			if (out_valid && out_ready) begin
				if (outcomes_due.size() == 0) begin
					$display("%0t: unexpected result item, found=%0b", $time, found);
					failures++;
				end else begin
					due = outcomes_due.pop_front();
					if (found !== due.hit) begin
						$display("%0t: found mismatch for target %0d: expected %0b actual %0b",
							$time, due.key, due.hit, found);
						failures++;
					end
				end
			end
			pending <= outcomes_due.size();
		end
	end

endmodule

// ===== dv/sorted_matrix_search_test.sv =====
`timescale 1ns / 100ps
// Testbench top for the sorted matrix search block: stimulus, idling and verdict.
module sorted_matrix_search_test;
	import sms_pkg::*;

	localparam int GRID         = 32;
	localparam int ITEM_GOAL    = 1500;
	localparam int STALL_LIMIT  = 5000;
	localparam int DRAIN_CYCLES = 70;
	localparam logic signed [DATA_W-1:0] TOP_WORD    = 32'sh7fff_ffff;
	localparam logic signed [DATA_W-1:0] BOTTOM_WORD = 32'sh8000_0000;
	localparam longint WORD_MAX = 64'sd2147483647;
	localparam longint WORD_MIN = -64'sd2147483648;

	logic                     clk          = 1'b0;
	logic                     arst_n       = 1'b0;
	logic                     cfg_write    = 1'b0;
	logic                     cfg_index    = REG_ROW_COUNT;
	logic [COUNT_W-1:0]       cfg_data     = '0;
	logic                     in_valid     = 1'b0;
	logic                     in_ready;
	logic                     func         = FUNC_WRITE;
	logic [INDEX_W-1:0]       row_index    = '0;
	logic [INDEX_W-1:0]       column_index = '0;
	logic signed [DATA_W-1:0] entry_value  = '0;
	logic signed [DATA_W-1:0] target       = '0;
	logic                     out_valid;
	logic                     out_ready    = 1'b0;
	logic                     found;

	int pending;
	int fail_count;
	int sent = 0;
	int quiet_cycles = 0;
	bit calm = 1'b0;
	int live_rows = 0;
	int live_cols = 0;

	// Contents the stimulus has loaded, used to aim queries at real entries
	logic signed [DATA_W-1:0] grid_val [GRID][GRID];

	sorted_matrix_search uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_write    (cfg_write),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.func         (func),
		.row_index    (row_index),
		.column_index (column_index),
		.entry_value  (entry_value),
		.target       (target),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.found        (found)
	);

	sorted_matrix_search_check checker_i (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_write    (cfg_write),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.func         (func),
		.row_index    (row_index),
		.column_index (column_index),
		.entry_value  (entry_value),
		.target       (target),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.found        (found),
		.pending      (pending),
		.failures     (fail_count)
	);

	always #1 clk = ~clk;

	// Result side stalls at random unless in a calm stretch
	always @(posedge clk) begin
		out_ready <= calm || ($urandom_range(0, 99) >= 22);
	end

	// Watchdog: give up after too many cycles with no handshake at all
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_write) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= STALL_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// Present one item, with a random gap first, and hold it until accepted
	task automatic send(input logic f, input logic [INDEX_W-1:0] r, input logic [INDEX_W-1:0] c,
			input logic signed [DATA_W-1:0] v, input logic signed [DATA_W-1:0] t);
		while (!calm && $urandom_range(0, 99) < 22) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid     <= 1'b1;
		func         <= f;
		row_index    <= r;
		column_index <= c;
		entry_value  <= v;
		target       <= t;
		do @(posedge clk); while (!in_ready);
		sent++;
	endtask

	task automatic put_entry(input int r, input int c, input logic signed [DATA_W-1:0] v);
		grid_val[r][c] = v;
		send(FUNC_WRITE, r[INDEX_W-1:0], c[INDEX_W-1:0], v, $urandom());
	endtask

	task automatic ask(input logic signed [DATA_W-1:0] t);
		send(FUNC_QUERY, INDEX_W'($urandom()), INDEX_W'($urandom()), $urandom(), t);
	endtask

	// Stop sending, let every result come back, then let the block go quiet
	task automatic settle();
		in_valid <= 1'b0;
		// the count is registered, so it lags the last accept
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Both count registers, written back to back while idle
	task automatic set_dims(input logic [COUNT_W-1:0] rows, input logic [COUNT_W-1:0] cols);
		cfg_write <= 1'b1;
		cfg_index <= REG_ROW_COUNT;
		cfg_data  <= rows;
		@(posedge clk);
		cfg_index <= REG_COLUMN_COUNT;
		cfg_data  <= cols;
		@(posedge clk);
		cfg_write <= 1'b0;
		live_rows = (rows > GRID) ? GRID : int'(rows);
		live_cols = (cols > GRID) ? GRID : int'(cols);
	endtask

	function automatic logic [COUNT_W-1:0] pick_count();
		case ($urandom_range(0, 19))
			0:       return '0;
			1:       return COUNT_W'($urandom_range(33, 63));
			2:       return COUNT_W'(GRID);
			default: return COUNT_W'($urandom_range(1, 8));
		endcase
	endfunction

	// Load the whole live area, either sorted both ways or scrambled
	task automatic fill_area(input bit ordered);
		longint lo;
		longint v;
		int unsigned step;
		case ($urandom_range(0, 3))
			0:       lo = WORD_MIN;
			1:       lo = longint'($signed($urandom()));
			2:       lo = longint'(int'($urandom_range(0, 200)) - 100);
			default: lo = WORD_MAX - longint'($urandom_range(0, 64));
		endcase
		case ($urandom_range(0, 3))
			0:       step = 2;
			1:       step = 8;
			2:       step = 1000;
			default: step = 1 << 26;
		endcase
		for (int r = 0; r < live_rows; r++) begin
			for (int c = 0; c < live_cols; c++) begin
				if (ordered) begin
					v = lo;
					if (r > 0 && longint'(grid_val[r-1][c]) > v)
						v = grid_val[r-1][c];
					if (c > 0 && longint'(grid_val[r][c-1]) > v)
						v = grid_val[r][c-1];
					if (r > 0 || c > 0)
						v = v + longint'($urandom_range(0, step));
					if (v > WORD_MAX)
						v = WORD_MAX;
				end else if ($urandom_range(0, 1) == 0) begin
					v = longint'($signed($urandom()));
				end else begin
					v = longint'(int'($urandom_range(0, 20)) - 10);
				end
				put_entry(r, c, v[DATA_W-1:0]);
			end
		end
	endtask

	// Query mix: hits on real entries, near misses, random and extreme targets, stray writes
	task automatic query_burst(input int count);
		int r;
		int c;
		int pick;
		for (int k = 0; k < count; k++) begin
			pick = $urandom_range(0, 9);
			r = (live_rows > 0) ? $urandom_range(0, live_rows - 1) : 0;
			c = (live_cols > 0) ? $urandom_range(0, live_cols - 1) : 0;
			if (pick <= 6 && live_rows > 0 && live_cols > 0) begin
				if (pick <= 4)
					ask(grid_val[r][c]);
				else if (pick == 5)
					ask(grid_val[r][c] + 32'sd1);
				else
					ask(grid_val[r][c] - 32'sd1);
			end else if (pick == 8) begin
				case ($urandom_range(0, 3))
					0:       ask(BOTTOM_WORD);
					1:       ask(TOP_WORD);
					2:       ask(32'sd0);
					default: ask(-32'sd1);
				endcase
			end else if (pick == 9 && live_rows < GRID) begin
				// Outside the live rows, so the walk never sees it
				put_entry($urandom_range(live_rows, GRID - 1), $urandom_range(0, GRID - 1),
					$urandom());
			end else begin
				ask($urandom());
			end
		end
	endtask

	initial begin : stimulus
		int phase;
		int burst;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Empty matrix, including oversized counts paired with a zero
		set_dims(0, 0);
		ask(32'sd0);
		ask(BOTTOM_WORD);
		settle();
		set_dims(63, 0);
		ask(32'sd0);
		settle();
		set_dims(0, 63);
		ask(TOP_WORD);
		settle();

		// Two by two matrix holding both word extremes
		set_dims(2, 2);
		put_entry(0, 0, BOTTOM_WORD);
		put_entry(0, 1, 32'sd0);
		put_entry(1, 0, 32'sd5);
		put_entry(1, 1, TOP_WORD);
		put_entry(GRID - 1, GRID - 1, -32'sd1);
		put_entry(GRID - 1, 0, TOP_WORD);
		ask(BOTTOM_WORD);
		ask(32'sd0);
		ask(32'sd5);
		ask(TOP_WORD);
		ask(32'sd1);
		ask(-32'sd1);
		ask(TOP_WORD - 32'sd1);
		ask(32'sd6);
		settle();

		// Random phases: new sizes and contents each time, queries on top
		phase = 0;
		while (sent < ITEM_GOAL) begin
			calm = (phase == 3 || phase == 4);
			set_dims(pick_count(), pick_count());
			fill_area($urandom_range(0, 4) != 0);
			burst = live_rows * live_cols / 2 + $urandom_range(4, 16);
			query_burst((burst > 40) ? 40 : burst);
			settle();
			phase++;
		end

		if (fail_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
